### rtl/rac_pkg.sv
// Types, codes and constants of the range add / count-at-least block.
// Used by the controller, datapath and top level; no dependencies.
package rac_pkg;

	localparam int unsigned MAX_ELEMENTS = 1024;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned CNT_W = 11;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ADD   = 2'd1,
		OP_COUNT = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [IDX_W-1:0]  first_index;
		logic [IDX_W-1:0]  last_index;
		logic signed [31:0] operand_value;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             range_error;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic load_wr;
		logic begin_scan;
		logic acc;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic  range_bad;
		op_t   op;
		logic  at_last;
	} status_t;

endpackage

### rtl/rac_ctrl.sv
// Controller state machine of the range add / count-at-least block.
// Depends on rac_pkg; drives the datapath through rac_pkg::cmd_t.
module rac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rac_pkg::status_t  status,
	output rac_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              done
);

	rac_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			rac_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d = rac_pkg::ST_CHECK;
				end
			end
			rac_pkg::ST_CHECK: begin
				if (status.range_bad || status.op == rac_pkg::OP_NONE) begin
					state_d = rac_pkg::ST_DONE;
				end else if (status.op == rac_pkg::OP_LOAD) begin
					cmd.load_wr = 1'b1;
					state_d = rac_pkg::ST_DONE;
				end else begin
					cmd.begin_scan = 1'b1;
					state_d = rac_pkg::ST_READ;
				end
			end
			rac_pkg::ST_READ: begin
				state_d = rac_pkg::ST_ACC;
			end
			rac_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				if (status.at_last) begin
					state_d = rac_pkg::ST_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d = rac_pkg::ST_READ;
				end
			end
			rac_pkg::ST_DONE: begin
				done = 1'b1;
				state_d = rac_pkg::ST_IDLE;
			end
			default: begin
				state_d = rac_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/rac_dp.sv
// Datapath of the range add / count-at-least block: element memory,
// scan index, count accumulator and range check. Depends on rac_pkg.
module rac_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rac_pkg::cmd_t              cmd,
	input  rac_pkg::item_t             item,
	input  logic                       cfg_we,
	input  logic [rac_pkg::CNT_W-1:0]  cfg_data,
	output rac_pkg::status_t           status,
	output rac_pkg::result_t           result
);

	localparam logic [rac_pkg::CNT_W-1:0] MaxN = rac_pkg::CNT_W'(rac_pkg::MAX_ELEMENTS);

	logic [31:0]                 mem [rac_pkg::MAX_ELEMENTS];
	rac_pkg::item_t              item_q;
	logic [rac_pkg::IDX_W-1:0]   idx_q;
	logic [rac_pkg::CNT_W-1:0]   cnt_q;
	logic [rac_pkg::CNT_W-1:0]   elem_cnt_q;
	logic [31:0]                 rdata_q;
	logic [rac_pkg::CNT_W-1:0]   usable;
	logic                        we;
	logic [rac_pkg::IDX_W-1:0]   waddr;
	logic [31:0]                 wdata;
	logic                        is_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q <= MaxN;
		end else if (cfg_we) begin
			elem_cnt_q <= cfg_data;
		end
	end

	assign usable = (elem_cnt_q > MaxN) ? MaxN : elem_cnt_q;
	assign is_add = item_q.opcode == rac_pkg::OP_ADD;

	always_comb begin
		status.op = rac_pkg::op_t'(item_q.opcode);
		status.at_last = idx_q == item_q.last_index;
		if (item_q.opcode == rac_pkg::OP_LOAD) begin
			status.range_bad = {1'b0, item_q.first_index} >= usable;
		end else if (item_q.opcode != rac_pkg::OP_NONE) begin
			status.range_bad = (item_q.first_index > item_q.last_index) ||
				({1'b0, item_q.last_index} >= usable);
		end else begin
			status.range_bad = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.begin_scan) begin
			idx_q <= item_q.first_index;
		end else if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.capture) begin
			cnt_q <= '0;
		end else if (cmd.acc && item_q.opcode == rac_pkg::OP_COUNT &&
				$signed(rdata_q) >= item_q.operand_value) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign we = cmd.load_wr || (cmd.acc && is_add);
	assign waddr = cmd.load_wr ? item_q.first_index : idx_q;
	assign wdata = cmd.load_wr ? item_q.operand_value : rdata_q + item_q.operand_value;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[idx_q];
	end

	assign result.count = cnt_q;
	assign result.range_error = status.range_bad;

endmodule

### rtl/range_add_count_at_least.sv
// Top level of the range add / count-at-least block.
// Depends on rac_pkg, rac_ctrl and rac_dp.
// An item is taken when start is high and busy is low; its single result
// appears on result for one cycle with done high and must be taken then,
// since the receiver cannot stall. A load or a flagged or unknown item goes
// from CHECK to DONE; an add or count visits its range one element at a time
// in a READ state, which registers the element, and an ACC state, which
// updates or counts it. The user must write the element_count register on
// the cfg channel only while the block is idle; the block does not check.
module range_add_count_at_least (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  rac_pkg::item_t                  item,
	output logic                            done,
	output rac_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rac_pkg::CNT_W-1:0]       cfg_data
);

	rac_pkg::cmd_t    cmd;
	rac_pkg::status_t status;

	assign cfg_ready = 1'b1;

	rac_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	rac_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.status   (status),
		.result   (result)
	);

endmodule

### tb/tb.sv
// Self-checking testbench for range_add_count_at_least: a clocked driver
// feeds items from a queue, a clocked monitor checks each result against a
// software model of the array. Depends on rac_pkg and the RTL top level.
module tb;

	localparam int unsigned LIMIT = 20000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	rac_pkg::item_t item = '0;
	logic done;
	rac_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rac_pkg::CNT_W-1:0] cfg_data = '0;

	range_add_count_at_least uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rac_pkg::item_t pending_items[$];
	rac_pkg::result_t expected_results[$];
	logic [31:0] true_value[rac_pkg::MAX_ELEMENTS];
	logic [rac_pkg::CNT_W-1:0] elem_count_reg = rac_pkg::CNT_W'(1024);
	int errors = 0;
	int unsigned cycles = 0;
	int gap_left = 0;
	int calm_left = 0;

	function automatic int unsigned usable();
		return (elem_count_reg > rac_pkg::MAX_ELEMENTS) ? rac_pkg::MAX_ELEMENTS :
			elem_count_reg;
	endfunction

	function automatic rac_pkg::result_t apply_item(rac_pkg::item_t it);
		rac_pkg::result_t r;
		int unsigned n;
		r = '0;
		n = usable();
		case (rac_pkg::op_t'(it.opcode))
			rac_pkg::OP_LOAD: begin
				if (it.first_index >= n) r.range_error = 1'b1;
				else true_value[it.first_index] = it.operand_value;
			end
			rac_pkg::OP_ADD, rac_pkg::OP_COUNT: begin
				if (it.first_index > it.last_index || it.last_index >= n) begin
					r.range_error = 1'b1;
				end else begin
					for (int i = it.first_index; i <= it.last_index; i++) begin
						if (rac_pkg::op_t'(it.opcode) == rac_pkg::OP_ADD)
							true_value[i] = true_value[i] + it.operand_value;
						else if ($signed(true_value[i]) >= it.operand_value)
							r.count = r.count + 1'b1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int draw_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				expected_results.push_back(apply_item(item));
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_items.size() > 0) begin
				item <= pending_items.pop_front();
				start <= 1'b1;
				gap_left <= draw_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result count=%0d err=%0b", $time,
					result.count, result.range_error);
				errors++;
			end else begin
				rac_pkg::result_t e;
				e = expected_results.pop_front();
				if (result.count !== e.count || result.range_error !== e.range_error) begin
					$display("%0t: mismatch expected count=%0d err=%0b actual count=%0d err=%0b",
						$time, e.count, e.range_error, result.count, result.range_error);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] draw_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'($signed($urandom_range(0, 40)) - 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic rac_pkg::item_t make_item(rac_pkg::item_t it_op, int unsigned lo,
		int unsigned hi, logic [31:0] v);
		rac_pkg::item_t it;
		it = it_op;
		it.first_index = rac_pkg::IDX_W'(lo);
		it.last_index = rac_pkg::IDX_W'(hi);
		it.operand_value = v;
		return it;
	endfunction

	function automatic rac_pkg::item_t random_item();
		rac_pkg::item_t it;
		int r;
		int unsigned n, len, lo;
		n = usable();
		it = '0;
		it.operand_value = draw_value();
		r = $urandom_range(0, 99);
		if (r < 25) it.opcode = rac_pkg::OP_LOAD;
		else if (r < 57) it.opcode = rac_pkg::OP_ADD;
		else if (r < 96) it.opcode = rac_pkg::OP_COUNT;
		else it.opcode = rac_pkg::OP_NONE;
		r = $urandom_range(0, 99);
		if (n == 0 || r < 8) begin
			it.first_index = rac_pkg::IDX_W'($urandom);
			it.last_index = rac_pkg::IDX_W'($urandom);
			if (n == 1024 && it.first_index <= it.last_index) begin
				it.first_index = it.last_index + 1'b1;
				if (it.last_index == '1) it.last_index = '0;
			end
			return it;
		end
		if (it.opcode == rac_pkg::OP_LOAD) begin
			it.first_index = rac_pkg::IDX_W'($urandom_range(0, n - 1));
			it.last_index = rac_pkg::IDX_W'($urandom);
			return it;
		end
		if (r < 80) len = $urandom_range(1, 40);
		else if (r < 97) len = $urandom_range(1, 200);
		else len = $urandom_range(1, n);
		if (len > n) len = n;
		lo = $urandom_range(0, n - len);
		it.first_index = rac_pkg::IDX_W'(lo);
		it.last_index = rac_pkg::IDX_W'(lo + len - 1);
		if (it.opcode == rac_pkg::OP_COUNT && $urandom_range(0, 2) == 0)
			it.operand_value = true_value[$urandom_range(lo, lo + len - 1)];
		return it;
	endfunction

	task automatic drain();
		while (pending_items.size() > 0 || start || busy || expected_results.size() > 0)
			@(negedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_count(int unsigned v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= rac_pkg::CNT_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		elem_count_reg = rac_pkg::CNT_W'(v);
	endtask

	task automatic run_random(int unsigned num);
		repeat (num) pending_items.push_back(random_item());
		drain();
	endtask

	initial begin
		rac_pkg::item_t op_load, op_add, op_count, op_none;
		op_load = '0; op_load.opcode = rac_pkg::OP_LOAD;
		op_add = '0; op_add.opcode = rac_pkg::OP_ADD;
		op_count = '0; op_count.opcode = rac_pkg::OP_COUNT;
		op_none = '0; op_none.opcode = rac_pkg::OP_NONE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		write_count(1024);

		for (int i = 0; i < rac_pkg::MAX_ELEMENTS; i++)
			pending_items.push_back(make_item(op_load, i, $urandom, draw_value()));
		drain();

		pending_items.push_back(make_item(op_load, 0, 0, 32'h8000_0000));
		pending_items.push_back(make_item(op_load, 1023, 1023, 32'h7FFF_FFFF));
		pending_items.push_back(make_item(op_count, 0, 1023, 32'h8000_0000));
		pending_items.push_back(make_item(op_count, 0, 1023, 32'h7FFF_FFFF));
		pending_items.push_back(make_item(op_add, 1023, 1023, 32'h0000_0001));
		pending_items.push_back(make_item(op_count, 1023, 1023, 32'h8000_0000));
		pending_items.push_back(make_item(op_add, 0, 0, 32'hFFFF_FFFF));
		pending_items.push_back(make_item(op_count, 0, 0, 32'h7FFF_FFFF));
		pending_items.push_back(make_item(op_add, 5, 100, 32'h4000_0000));
		pending_items.push_back(make_item(op_count, 0, 127, 32'h0000_0000));
		pending_items.push_back(make_item(op_add, 32, 63, 32'h8000_0000));
		pending_items.push_back(make_item(op_count, 32, 63, 32'hC000_0000));
		pending_items.push_back(make_item(op_add, 0, 1023, 32'h7FFF_FFFF));
		pending_items.push_back(make_item(op_count, 1, 1022, 32'h0000_0001));
		pending_items.push_back(make_item(op_count, 10, 9, 32'h0));
		pending_items.push_back(make_item(op_add, 1023, 0, 32'h1));
		pending_items.push_back(make_item(op_none, 0, 1023, 32'h1234_5678));
		pending_items.push_back(make_item(op_count, 500, 500, 32'h8000_0000));
		drain();

		run_random(100);
		write_count(37);
		pending_items.push_back(make_item(op_load, 37, 0, 32'h1));
		pending_items.push_back(make_item(op_count, 0, 37, 32'h0));
		pending_items.push_back(make_item(op_count, 0, 36, 32'h0));
		run_random(60);
		write_count(0);
		run_random(20);
		write_count(2047);
		run_random(100);
		write_count(1);
		run_random(25);
		write_count(1024);
		run_random(100);

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
